// ===== design/tsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, constants and coefficient table for the temperature filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int CountWidth  = 10;
   localparam int SampleWidth = 16;
   localparam int ResultWidth = 17;
   localparam int AccWidth    = 32;
   localparam int CoefWidth   = 16;
   localparam int NumTaps     = 7;
   localparam int TapWidth    = 3;
   localparam int QShift      = 15;

   localparam logic [TapWidth-1:0] LastTap = TapWidth'(NumTaps - 1);
   localparam logic signed [AccWidth-1:0] RoundHalf = AccWidth'(1 << (QShift - 1));

   typedef logic [CountWidth-1:0]         count_type;
   typedef logic [SampleWidth-1:0]        sample_type;
   typedef logic signed [ResultWidth-1:0] result_type;
   typedef logic signed [AccWidth-1:0]    acc_type;
   typedef logic signed [CoefWidth-1:0]   coef_type;
   typedef logic [TapWidth-1:0]           tap_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    clear;
      logic    step;
      tap_type tap;
   } mac_ctrl_type;

   // symmetric q15 low-pass taps
   function automatic coef_type coef_at(input tap_type tap);
      coef_type c;
      unique case (tap)
         3'd0:    c = -16'sd3133;
         3'd1:    c = 16'sd1534;
         3'd2:    c = 16'sd10315;
         3'd3:    c = 16'sd14828;
         3'd4:    c = 16'sd10315;
         3'd5:    c = 16'sd1534;
         3'd6:    c = -16'sd3133;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== design/tsf_scale.sv =====
// ----------------------------------------------------------------------------
// tsf_scale
// Converts a raw converter count to 1/64 degree, Celsius or Fahrenheit.
// ----------------------------------------------------------------------------
module tsf_scale (
   input  tsf_pkg::count_type  count,
   input  logic                use_fahrenheit,
   output tsf_pkg::sample_type sample
);
   import tsf_pkg::*;

   logic [18:0] prod_c;
   logic [18:0] prod_f;
   logic [15:0] temp_c;
   logic [15:0] temp_f;

   always_comb begin
      prod_c = 19'(count) * 19'd165 + 19'd4;
      prod_f = 19'(count) * 19'd297 + 19'd4;
      temp_c = 16'(prod_c >> 3);
      temp_f = 16'(prod_f >> 3) + 16'd2048;
      sample = use_fahrenheit ? temp_f : temp_c;
   end

endmodule

// ===== design/tsf_cell.sv =====
// ----------------------------------------------------------------------------
// tsf_cell
// One history cell: holds a sample and passes it to its right neighbor.
// ----------------------------------------------------------------------------
module tsf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  tsf_pkg::sample_type d_in,
   output tsf_pkg::sample_type q
);
   import tsf_pkg::*;

   sample_type sample_ff;
   sample_type sample_in;

   always_comb begin
      sample_in = shift_en ? d_in : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign q = sample_ff;

endmodule

// ===== design/tsf_mac.sv =====
// ----------------------------------------------------------------------------
// tsf_mac
// Multiply-accumulate of one tap per cycle with q15 rounding of the sum.
// ----------------------------------------------------------------------------
module tsf_mac (
   input  logic                  clock,
   input  tsf_pkg::mac_ctrl_type ctrl,
   input  tsf_pkg::sample_type   sample,
   output tsf_pkg::result_type   result
);
   import tsf_pkg::*;

   acc_type acc_ff;
   acc_type acc_in;
   acc_type product;
   acc_type rounded;

   always_comb begin
      product = AccWidth'(coef_at(ctrl.tap)) * $signed({1'b0, sample});
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.step) begin
         acc_in = acc_ff + product;
      end else begin
         acc_in = acc_ff;
      end
      rounded = acc_ff + RoundHalf;
      result  = rounded[QShift +: ResultWidth];
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// ===== design/temperature_scale_fir_filter.sv =====
// ----------------------------------------------------------------------------
// temperature_scale_fir_filter
// Scales converter counts to temperature and low-pass filters them, 7 taps.
// ----------------------------------------------------------------------------
// flow: an input transfer clears the mac and loads a new sample into the cell row,
// then the single mac runs the 7 tap steps while the cell row rotates once per item;
// a new input is accepted only in IDLE, or in DONE once the output is free
// reset: synchronous, clears history, scale select and result valid
// ----------------------------------------------------------------------------
module temperature_scale_fir_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_use_fahrenheit,
   input  logic                req_valid,
   output logic                req_stall,
   input  tsf_pkg::count_type  req_adc_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tsf_pkg::result_type rsp_filtered_temp
);
   import tsf_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   tap_type      tap_ff;
   tap_type      tap_in;
   logic         fahr_ff;
   logic         fahr_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   result_type   rsp_temp_ff;
   result_type   rsp_temp_in;

   logic         accept;
   logic         out_free;
   logic         load_out;
   logic         shift_en;
   mac_ctrl_type mac_ctrl;
   sample_type   new_sample;
   sample_type   cell_q [NumTaps];
   sample_type   head_in;
   result_type   mac_result;

   tsf_scale u_scale (
      .count          (req_adc_count),
      .use_fahrenheit (fahr_ff),
      .sample         (new_sample)
   );

   assign head_in = accept ? new_sample : cell_q[NumTaps-1];

   for (genvar i = 0; i < NumTaps; i++) begin : g_cell
      tsf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     ((i == 0) ? head_in : cell_q[(i == 0) ? 0 : i-1]),
         .q        (cell_q[i])
      );
   end

   tsf_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (cell_q[NumTaps-1]),
      .result (mac_result)
   );

   // outputs
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_DONE: req_stall = !out_free;
         default: req_stall = 1'b1;
      endcase
      accept        = req_valid && !req_stall;
      load_out      = (state_ff == ST_DONE) && out_free;
      shift_en      = accept || (state_ff == ST_RUN);
      mac_ctrl.clear = accept;
      mac_ctrl.step  = (state_ff == ST_RUN);
      mac_ctrl.tap   = tap_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (tap_ff == LastTap) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (accept) begin
               state_in = ST_RUN;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (accept) begin
         tap_in = '0;
      end else if (state_ff == ST_RUN) begin
         tap_in = tap_ff + TapWidth'(1);
      end else begin
         tap_in = tap_ff;
      end
      fahr_in      = csr_wr_en ? csr_use_fahrenheit : fahr_ff;
      rsp_temp_in  = load_out ? mac_result : rsp_temp_ff;
      priority if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         fahr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         fahr_ff      <= fahr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_temp = rsp_temp_ff;

endmodule
